FILE: rtl/gf2m_arithmetic_unit_assert.svh
// assertion macros for the gf2m arithmetic unit
`ifndef GF2M_ARITHMETIC_UNIT_ASSERT_SVH
`define GF2M_ARITHMETIC_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define GF2M_ASSERT_IMPL(label, clk, rst_n, cond, consq) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (consq)) \
        else $error("assertion failed");
`define GF2M_ASSERT_NEXT(label, clk, rst_n, cond, consq) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (consq)) \
        else $error("assertion failed");
`else
`define GF2M_ASSERT_IMPL(label, clk, rst_n, cond, consq)
`define GF2M_ASSERT_NEXT(label, clk, rst_n, cond, consq)
`endif
`endif

FILE: rtl/gf2m_pkg.sv
// package: operation codes, widths and defaults for the gf2m arithmetic unit
package gf2m_pkg;
    localparam int DEFAULT_MAX_DEGREE = 32;
    localparam int DEG_W = 6;
    localparam int DATA_W = 32;
    localparam logic [DEG_W-1:0] RESET_DEGREE = 6'd8;
    localparam logic [DATA_W-1:0] RESET_POLY = 32'd27;

    typedef enum logic [2:0] {
        OP_ADD = 3'd0, OP_SUB = 3'd1, OP_MUL = 3'd2, OP_DIV = 3'd3,
        OP_INV = 3'd4, OP_SQR = 3'd5, OP_TRACE = 3'd6, OP_POW = 3'd7
    } op_t;

    typedef enum logic [0:0] {
        REG_DEGREE = 1'b0, REG_POLY = 1'b1
    } reg_idx_t;
endpackage

FILE: rtl/gf2m_arithmetic_unit.sv
// gf2m arithmetic unit: sequencer around one bit-serial field multiplier
//
// channel   dir   contents
// s_axis    in    tdata: req_type[2:0], operand_a, operand_b, exponent (+pad)
// m_axis    out   tdata: result[31:0], error[32] (+pad)
// cfg       in    cfg_index selects degree (0) or polynomial (1), cfg_data value
//
// every multiply runs on the shared shift-and-add unit (m = degree, clamped to 2..MAX_DEGREE)
// multiplies per item: add/sub none; mul/square one; trace m-1 squarings;
// power 32 squarings and one multiply per set exponent bit
// inverse: m squarings, m-1 multiplies and a check multiply; divide one more
// s_tready is low from acceptance until the result is taken and while cfg_valid is high;
// reset is synchronous on aresetn and resets only the state, degree and polynomial registers
`include "gf2m_arithmetic_unit_assert.svh"
module gf2m_arithmetic_unit #(
    parameter int MAX_DEGREE = gf2m_pkg::DEFAULT_MAX_DEGREE
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    // req_type[2:0], operand_a[34:3], operand_b[66:35], exponent[98:67], zero pad
    input  logic [103:0]  s_axis_tdata,
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    // result[31:0], error[32], zero pad
    output logic [39:0]   m_axis_tdata,
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic [0:0]    cfg_index,
    input  logic [31:0]   cfg_data
);
    localparam int EW = MAX_DEGREE;
    localparam int CW = $clog2(MAX_DEGREE + 1) + 1;
    localparam int DW = gf2m_pkg::DATA_W;
    localparam int XW = (EW > DW) ? EW : DW;
    localparam int NW = $clog2(XW + 1);
    localparam int XIW = $clog2(XW);
    localparam int IW = $clog2(EW);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_SETUP = 7'b0000010,
        S_MUL   = 7'b0000100,
        S_NEXT  = 7'b0001000,
        S_DONE  = 7'b0010000,
        S_OUT   = 7'b0100000,
        S_CHK   = 7'b1000000
    } state_t;

    // what the multiplier result is used for
    typedef enum logic [2:0] {
        U_PLAIN, U_SQ, U_MULA, U_CHECK, U_DIVF, U_TSQ, U_FIN
    } use_t;

    state_t state_reg, state_next;
    logic [gf2m_pkg::DEG_W-1:0] deg_reg;
    logic [DW-1:0]  poly_reg;
    gf2m_pkg::op_t  op_reg;
    logic [EW-1:0]  a_reg, b_reg, r_reg, t_reg, s_reg;
    logic [XW-1:0]  e_reg;
    logic [NW-1:0]  ecnt_reg;   // exponent bits left
    logic           inv_reg;    // power computes inverse
    use_t           use_reg;
    logic [CW-1:0]  bit_reg;    // multiplier bits left
    logic [CW-1:0]  tcnt_reg;
    logic [EW-1:0]  acc_reg, ma_reg, mb_reg;
    logic [DW-1:0]  res_reg;
    logic           err_reg;
    logic           in_fire;
    logic           is_inv_op;
    logic           seq_done;

    // effective degree and masks
    logic [CW-1:0]  m_eff;
    logic [EW-1:0]  mask, pmask;
    always_comb begin
        if (deg_reg < 6'd2) m_eff = CW'(2);
        else if (32'(deg_reg) > MAX_DEGREE) m_eff = CW'(MAX_DEGREE);
        else m_eff = CW'(deg_reg);
        for (int i = 0; i < EW; i++) mask[i] = (i < int'(m_eff));
        pmask = EW'(poly_reg) & mask;
    end

    // one shift-and-add step
    logic [EW-1:0] acc_step;
    logic          top_bit;
    always_comb begin
        top_bit = acc_reg[IW'(m_eff - CW'(1))];
        acc_step = (acc_reg << 1) & mask;
        if (top_bit) acc_step = acc_step ^ pmask;
        if (mb_reg[IW'(bit_reg - CW'(1))]) acc_step = acc_step ^ ma_reg;
    end

    assign s_axis_tready = (state_reg == S_IDLE) && !cfg_valid;
    assign cfg_ready = (state_reg == S_IDLE);
    assign m_axis_tvalid = (state_reg == S_OUT);
    assign m_axis_tdata = {7'd0, err_reg, res_reg};
    assign in_fire = s_axis_tvalid && s_axis_tready;
    assign is_inv_op = (op_reg == gf2m_pkg::OP_DIV) || (op_reg == gf2m_pkg::OP_INV);

    // no further multiply is needed for the current item
    always_comb begin
        unique case (op_reg)
            gf2m_pkg::OP_ADD, gf2m_pkg::OP_SUB: seq_done = 1'b1;
            gf2m_pkg::OP_MUL, gf2m_pkg::OP_SQR: seq_done = (use_reg != U_PLAIN);
            gf2m_pkg::OP_TRACE: seq_done = (tcnt_reg >= m_eff);
            default: seq_done = !((use_reg == U_SQ && (ecnt_reg != '0 || inv_reg))
                                  || use_reg == U_MULA || use_reg == U_DIVF);
        endcase
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (in_fire) state_next = S_SETUP;
            S_SETUP: state_next = S_NEXT;
            S_MUL:   if (bit_reg == CW'(1)) state_next = S_NEXT;
            S_NEXT:  state_next = seq_done ? S_DONE : S_MUL;
            S_CHK:   state_next = S_NEXT;
            S_DONE:  state_next = S_OUT;
            S_OUT:   if (m_axis_tready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            deg_reg <= gf2m_pkg::RESET_DEGREE;
            poly_reg <= gf2m_pkg::RESET_POLY;
        end else begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready) begin
                unique case (gf2m_pkg::reg_idx_t'(cfg_index))
                    gf2m_pkg::REG_DEGREE: deg_reg <= cfg_data[gf2m_pkg::DEG_W-1:0];
                    gf2m_pkg::REG_POLY:   poly_reg <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // datapath and sequencing decisions
    logic [EW-1:0] prod;
    assign prod = acc_step;
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            S_IDLE: if (in_fire) begin
                op_reg <= gf2m_pkg::op_t'(s_axis_tdata[2:0]);
                a_reg <= EW'(s_axis_tdata[34:3]);
                b_reg <= EW'(s_axis_tdata[66:35]);
                e_reg <= XW'(s_axis_tdata[98:67]);
            end
            S_SETUP: begin
                // divide inverts b first and keeps a in t_reg for the final multiply
                a_reg <= ((op_reg == gf2m_pkg::OP_DIV) ? b_reg : a_reg) & mask;
                b_reg <= b_reg & mask;
                t_reg <= a_reg & mask;
                s_reg <= a_reg & mask;
                r_reg <= EW'(1);
                err_reg <= 1'b0;
                res_reg <= (op_reg == gf2m_pkg::OP_ADD || op_reg == gf2m_pkg::OP_SUB)
                           ? DW'((a_reg ^ b_reg) & mask) : '0;
                inv_reg <= is_inv_op;
                ecnt_reg <= is_inv_op ? NW'(m_eff) : NW'(DW);
                tcnt_reg <= CW'(1);
                if (is_inv_op) e_reg <= XW'(mask - EW'(1));
                unique case (op_reg)
                    gf2m_pkg::OP_DIV, gf2m_pkg::OP_INV, gf2m_pkg::OP_POW: use_reg <= U_SQ;
                    gf2m_pkg::OP_TRACE: use_reg <= U_TSQ;
                    default: use_reg <= U_PLAIN;
                endcase
            end
            S_NEXT: begin
                // choose the next multiply, or finish
                acc_reg <= '0;
                bit_reg <= m_eff;
                unique case (op_reg)
                    gf2m_pkg::OP_ADD, gf2m_pkg::OP_SUB: ;
                    gf2m_pkg::OP_MUL, gf2m_pkg::OP_SQR: begin
                        if (use_reg == U_PLAIN) begin
                            ma_reg <= a_reg;
                            mb_reg <= (op_reg == gf2m_pkg::OP_SQR) ? a_reg : b_reg;
                            use_reg <= U_CHECK;
                        end
                    end
                    gf2m_pkg::OP_TRACE: begin
                        if (tcnt_reg < m_eff) begin
                            ma_reg <= t_reg;
                            mb_reg <= t_reg;
                            tcnt_reg <= tcnt_reg + CW'(1);
                        end else begin
                            res_reg <= DW'(s_reg[0]);
                        end
                    end
                    default: begin
                        // power ladder, shared by inverse and divide
                        if (use_reg == U_SQ && ecnt_reg != '0) begin
                            ma_reg <= r_reg;
                            mb_reg <= r_reg;
                        end else if (use_reg == U_MULA) begin
                            ma_reg <= r_reg;
                            mb_reg <= a_reg;
                        end else if (use_reg == U_SQ && !inv_reg) begin
                            res_reg <= DW'(r_reg);
                        end else if (use_reg == U_SQ) begin
                            ma_reg <= a_reg;
                            mb_reg <= r_reg;
                            use_reg <= U_CHECK;
                        end else if (use_reg == U_DIVF) begin
                            ma_reg <= t_reg;
                            mb_reg <= r_reg;
                        end
                    end
                endcase
            end
            S_MUL: begin
                acc_reg <= acc_step;
                bit_reg <= bit_reg - CW'(1);
                if (bit_reg == CW'(1)) begin
                    unique case (use_reg)
                        U_SQ: begin
                            r_reg <= prod;
                            ecnt_reg <= ecnt_reg - NW'(1);
                            if (e_reg[XIW'(ecnt_reg - NW'(1))]) use_reg <= U_MULA;
                        end
                        U_MULA: begin
                            r_reg <= prod;
                            use_reg <= U_SQ;
                        end
                        U_TSQ: begin
                            t_reg <= prod;
                            s_reg <= s_reg ^ prod;
                        end
                        U_CHECK: begin
                            if (op_reg == gf2m_pkg::OP_MUL || op_reg == gf2m_pkg::OP_SQR) begin
                                res_reg <= DW'(prod);
                                use_reg <= U_FIN;
                            end else if (prod != EW'(1)) begin
                                err_reg <= 1'b1;
                                res_reg <= '0;
                                use_reg <= U_PLAIN;
                            end else if (op_reg == gf2m_pkg::OP_DIV) begin
                                use_reg <= U_DIVF;
                            end else begin
                                res_reg <= DW'(r_reg);
                                use_reg <= U_PLAIN;
                            end
                        end
                        U_DIVF: begin
                            res_reg <= DW'(prod);
                            use_reg <= U_PLAIN;
                        end
                        default: ;
                    endcase
                end
            end
            default: ;
        endcase
    end

    `GF2M_ASSERT_IMPL(a_out_idle, aclk, aresetn, m_axis_tvalid, !s_axis_tready)
    `GF2M_ASSERT_NEXT(a_hold, aclk, aresetn, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
    `GF2M_ASSERT_IMPL(a_err_zero, aclk, aresetn, m_axis_tvalid && err_reg, res_reg == '0)
endmodule

FILE: tb/tb_gf2m_arithmetic_unit.sv
// testbench for the gf2m arithmetic unit: random and directed items checked by a predictor
`timescale 1ns / 100ps
module tb_gf2m_arithmetic_unit;

    typedef struct packed {
        logic [31:0]   exponent;
        logic [31:0]   operand_b;
        logic [31:0]   operand_a;
        gf2m_pkg::op_t req_type;
    } field_req_t;

    typedef struct {
        logic [31:0] result;
        logic        error;
    } field_res_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [103:0] s_axis_tdata = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [39:0]  m_axis_tdata;
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic [0:0]   cfg_index = gf2m_pkg::REG_DEGREE;
    logic [31:0]  cfg_data = '0;

    gf2m_arithmetic_unit DUT (.*);

    always #6 aclk = ~aclk;

    // predictor copy of the configuration
    logic [5:0]  model_degree = gf2m_pkg::RESET_DEGREE;
    logic [31:0] model_poly = gf2m_pkg::RESET_POLY;

    field_req_t  pending_reqs[$];
    field_res_t  expected_results[$];
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    bit          hold_sender = 1'b0;
    bit          failed = 1'b0;
    longint      cycle_count = 0;

    function automatic logic [31:0] fmul(logic [31:0] a, logic [31:0] b, int m,
                                         logic [31:0] p, logic [31:0] mask);
        logic [31:0] acc;
        logic        top;
        acc = '0;
        for (int i = m - 1; i >= 0; i--) begin
            top = acc[m-1];
            acc = (acc << 1) & mask;
            if (top) acc ^= p;
            if (b[i]) acc ^= a;
        end
        return acc;
    endfunction

    function automatic logic [31:0] fpow(logic [31:0] a, logic [31:0] e, int nbits, int m,
                                         logic [31:0] p, logic [31:0] mask);
        logic [31:0] r;
        r = 32'd1;
        for (int i = nbits - 1; i >= 0; i--) begin
            r = fmul(r, r, m, p, mask);
            if (e[i]) r = fmul(r, a, m, p, mask);
        end
        return r;
    endfunction

    function automatic field_res_t predict_field_op(field_req_t rq);
        field_res_t  res;
        int          m;
        logic [31:0] mask, p, a, b, inv, t, s;
        m = model_degree < 2 ? 2 : (model_degree > 32 ? 32 : int'(model_degree));
        mask = (m == 32) ? 32'hFFFF_FFFF : ((32'd1 << m) - 1);
        p = model_poly & mask;
        a = rq.operand_a & mask;
        b = rq.operand_b & mask;
        res.result = '0;
        res.error = 1'b0;
        case (rq.req_type)
            gf2m_pkg::OP_ADD, gf2m_pkg::OP_SUB: res.result = a ^ b;
            gf2m_pkg::OP_MUL: res.result = fmul(a, b, m, p, mask);
            gf2m_pkg::OP_DIV: begin
                inv = fpow(b, mask - 1, m, m, p, mask);
                if (fmul(b, inv, m, p, mask) != 32'd1) res.error = 1'b1;
                else res.result = fmul(a, inv, m, p, mask);
            end
            gf2m_pkg::OP_INV: begin
                inv = fpow(a, mask - 1, m, m, p, mask);
                if (fmul(a, inv, m, p, mask) != 32'd1) res.error = 1'b1;
                else res.result = inv;
            end
            gf2m_pkg::OP_SQR: res.result = fmul(a, a, m, p, mask);
            gf2m_pkg::OP_TRACE: begin
                t = a;
                s = a;
                for (int i = 1; i < m; i++) begin
                    t = fmul(t, t, m, p, mask);
                    s ^= t;
                end
                res.result = {31'd0, s[0]};
            end
            default: res.result = fpow(a, rq.exponent, 32, m, p, mask);
        endcase
        return res;
    endfunction

    // driver
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_axis_tvalid && s_axis_tready) begin
                expected_results.push_back(predict_field_op(field_req_t'(s_axis_tdata[98:0])));
                void'(pending_reqs.pop_front());
            end
            if ((!s_axis_tvalid || s_axis_tready) && pending_reqs.size() > 0 && !hold_sender
                && ($urandom_range(99) >= send_idle_pct || s_axis_tvalid && s_axis_tready
                    && pending_reqs.size() > 1 && send_idle_pct == 0)) begin
                if (s_axis_tvalid && s_axis_tready) begin
                    if (pending_reqs.size() > 0) begin
                        s_axis_tvalid <= 1'b1;
                        s_axis_tdata <= {5'd0, pending_reqs[0]};
                    end else begin
                        s_axis_tvalid <= 1'b0;
                    end
                end else begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= {5'd0, pending_reqs[0]};
                end
            end else if (s_axis_tvalid && s_axis_tready) begin
                s_axis_tvalid <= 1'b0;
            end
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // monitor
    always @(posedge aclk) begin
        field_res_t exp_res;
        cycle_count <= cycle_count + 1;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (expected_results.size() == 0) begin
                $error("result item with nothing expected: %h", m_axis_tdata);
                failed = 1'b1;
            end else begin
                exp_res = expected_results.pop_front();
                if (m_axis_tdata[31:0] !== exp_res.result) begin
                    $error("result: expected %h, got %h", exp_res.result, m_axis_tdata[31:0]);
                    failed = 1'b1;
                end
                if (m_axis_tdata[32] !== exp_res.error) begin
                    $error("error: expected %b, got %b", exp_res.error, m_axis_tdata[32]);
                    failed = 1'b1;
                end
            end
        end
        if (cycle_count > 3000000) begin
            $display("tb_gf2m_arithmetic_unit: FAIL");
            $finish;
        end
    end

    task automatic push_req(gf2m_pkg::op_t op, logic [31:0] a, logic [31:0] b,
                            logic [31:0] e);
        field_req_t rq;
        rq.req_type = op;
        rq.operand_a = a;
        rq.operand_b = b;
        rq.exponent = e;
        pending_reqs.push_back(rq);
    endtask

    task automatic drain_results();
        while (pending_reqs.size() > 0 || s_axis_tvalid || expected_results.size() > 0)
            @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic write_reg(gf2m_pkg::reg_idx_t idx, logic [31:0] value);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == gf2m_pkg::REG_DEGREE) model_degree = value[5:0];
        else model_poly = value;
    endtask

    task automatic push_random(int count);
        gf2m_pkg::op_t op;
        logic [31:0]   a, b, e;
        for (int i = 0; i < count; i++) begin
            op = gf2m_pkg::op_t'($urandom_range(7));
            a = $urandom;
            b = $urandom_range(9) == 0 ? 32'd0 : $urandom;
            case ($urandom_range(3))
                0: e = $urandom_range(16);
                1: e = $urandom;
                default: e = $urandom_range(1000);
            endcase
            push_req(op, a, b, e);
        end
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // directed items with the reset field, GF(2^8)
        push_req(gf2m_pkg::OP_ADD, 32'hFFFF_FFFF, 32'h0000_0055, 32'd0);
        push_req(gf2m_pkg::OP_SUB, 32'h0000_00A3, 32'hFFFF_FFFF, 32'd0);
        push_req(gf2m_pkg::OP_MUL, 32'h0000_0057, 32'h0000_0083, 32'd0);
        push_req(gf2m_pkg::OP_MUL, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0);
        push_req(gf2m_pkg::OP_DIV, 32'h0000_0011, 32'h0000_0000, 32'd0);
        push_req(gf2m_pkg::OP_DIV, 32'h0000_0011, 32'hFFFF_FF00, 32'd0);
        push_req(gf2m_pkg::OP_DIV, 32'h0000_00C4, 32'h0000_0053, 32'd0);
        push_req(gf2m_pkg::OP_INV, 32'h0000_0000, 32'hFFFF_FFFF, 32'd0);
        push_req(gf2m_pkg::OP_INV, 32'h0000_0053, 32'd0, 32'hFFFF_FFFF);
        push_req(gf2m_pkg::OP_INV, 32'h0000_0001, 32'd0, 32'd0);
        push_req(gf2m_pkg::OP_SQR, 32'hFFFF_FFFF, 32'd0, 32'd0);
        push_req(gf2m_pkg::OP_TRACE, 32'h0000_0001, 32'd0, 32'd0);
        push_req(gf2m_pkg::OP_TRACE, 32'h0000_00FF, 32'd0, 32'd0);
        push_req(gf2m_pkg::OP_POW, 32'h0000_0000, 32'd0, 32'd0);
        push_req(gf2m_pkg::OP_POW, 32'h0000_0003, 32'd0, 32'hFFFF_FFFF);
        push_req(gf2m_pkg::OP_POW, 32'h0000_0002, 32'd0, 32'h8000_0000);
        push_req(gf2m_pkg::OP_POW, 32'h0000_0000, 32'd0, 32'd5);
        drain_results();

        // field settings, idling phases rotate through them
        for (int phase = 0; phase < 8; phase++) begin
            case (phase)
                0: begin
                    write_reg(gf2m_pkg::REG_DEGREE, 32'd32);
                    write_reg(gf2m_pkg::REG_POLY, 32'h0000_008D);
                end
                1: begin
                    write_reg(gf2m_pkg::REG_DEGREE, 32'd2);
                    write_reg(gf2m_pkg::REG_POLY, 32'hFFFF_FFFF);
                end
                2: begin
                    write_reg(gf2m_pkg::REG_DEGREE, 32'd0);
                    write_reg(gf2m_pkg::REG_POLY, 32'h0000_0003);
                end
                3: begin
                    write_reg(gf2m_pkg::REG_DEGREE, 32'd63);
                    write_reg(gf2m_pkg::REG_POLY, 32'd0);
                end
                4: begin
                    write_reg(gf2m_pkg::REG_DEGREE, 32'd4);
                    write_reg(gf2m_pkg::REG_POLY, 32'h0000_0005);
                end
                5: begin
                    write_reg(gf2m_pkg::REG_DEGREE, 32'd13);
                    write_reg(gf2m_pkg::REG_POLY, 32'h0000_001B);
                end
                6: begin
                    write_reg(gf2m_pkg::REG_DEGREE, 32'd1);
                    write_reg(gf2m_pkg::REG_POLY, 32'd1);
                end
                default: begin
                    write_reg(gf2m_pkg::REG_DEGREE, 32'd8);
                    write_reg(gf2m_pkg::REG_POLY, gf2m_pkg::RESET_POLY);
                end
            endcase
            case (phase % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 55; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 55; end
                default: begin send_idle_pct = 37; recv_stall_pct = 37; end
            endcase
            push_random(17);
            // let the queue empty before the sender continues
            if (phase == 3) begin
                hold_sender = 1'b1;
                while (s_axis_tvalid || expected_results.size() > 0) @(posedge aclk);
                hold_sender = 1'b0;
            end
            push_random(17);
            drain_results();
        end

        if (failed) $display("tb_gf2m_arithmetic_unit: FAIL");
        else $display("tb_gf2m_arithmetic_unit: PASS");
        $finish;
    end
endmodule

FILE: filelist.f
+incdir+rtl
rtl/gf2m_pkg.sv
rtl/gf2m_arithmetic_unit.sv
tb/tb_gf2m_arithmetic_unit.sv
